// File: hdl/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");

`endif

// File: hdl/tlbt_pkg.sv
package tlbt_pkg;
  localparam int TlbEntries = 16;
  localparam int IdxW       = $clog2(TlbEntries);
  localparam int CntW       = $clog2(TlbEntries + 1);

  localparam logic [1:0] CMD_TRANSLATE = 2'd0;
  localparam logic [1:0] CMD_FILL      = 2'd1;
  localparam logic [1:0] CMD_FLUSH     = 2'd2;

  localparam logic [1:0] ST_HIT   = 2'd0;
  localparam logic [1:0] ST_MISS  = 2'd1;
  localparam logic [1:0] ST_FILL  = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  localparam logic [1:0] REG_PAGE_SIZE = 2'd0;
  localparam logic [1:0] REG_EPT       = 2'd1;
  localparam logic [1:0] REG_POLICY    = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture the item and load the address divider
    logic div_step;   // one quotient bit
    logic load_div2;  // load page number into divider for table indexes
    logic scan_clr;   // reset the table scan
    logic scan_step;  // look at one entry
    logic hit_update; // stamp the hit entry
    logic fill_write; // install the fill
    logic flush;      // clear all entries
    logic emit;       // present a result
  } tlbt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_last;
    logic scan_last;
    logic hit;
  } tlbt_sts_t;
endpackage

// File: hdl/tlbt_ctrl.sv
module tlbt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        in_command,
  output logic              busy,
  output tlbt_pkg::tlbt_cmd_t cmd,
  input  tlbt_pkg::tlbt_sts_t sts
);
  import tlbt_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DIV1  = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_DIV2  = 7'b0001000,
    S_HIT   = 7'b0010000,
    S_FSCAN = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          cmd.scan_clr = 1'b1;
          case (in_command)
            CMD_TRANSLATE: state_nxt = S_DIV1;
            CMD_FILL:      state_nxt = S_FSCAN;
            CMD_FLUSH:     state_nxt = S_DONE;
            default:       state_nxt = S_IDLE;
          endcase
        end
      end
      S_DIV1: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.hit) state_nxt = S_HIT;
        else if (sts.scan_last) begin
          cmd.load_div2 = 1'b1;
          state_nxt = S_DIV2;
        end
      end
      S_DIV2: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_DONE;
      end
      S_HIT: begin
        cmd.hit_update = 1'b1;
        state_nxt = S_DONE;
      end
      S_FSCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          cmd.fill_write = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        cmd.emit = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assign busy = (state_r != S_IDLE);
endmodule

// File: hdl/tlbt_dp.sv
module tlbt_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  tlbt_pkg::tlbt_cmd_t cmd,
  output tlbt_pkg::tlbt_sts_t sts,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic [1:0]        in_command,
  input  logic [31:0]       in_logical_address,
  input  logic [31:0]       in_fill_page,
  input  logic [19:0]       in_fill_frame,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [19:0]       out_frame,
  output logic [15:0]       out_offset,
  output logic [31:0]       out_page_number,
  output logic [31:0]       out_first_level_index,
  output logic [15:0]       out_second_level_index
);
  import tlbt_pkg::*;

  logic [15:0] page_size_r, ept_r;
  logic        policy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_size_r <= 16'd64;
      ept_r <= 16'd4;
      policy_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PAGE_SIZE: page_size_r <= cfg_data;
        REG_EPT:       ept_r <= cfg_data;
        REG_POLICY:    policy_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // captured item
  logic [1:0]  op_r;
  logic [31:0] fpage_r;
  logic [19:0] fframe_r;

  // restoring divider, one quotient bit a cycle
  logic [31:0] quo_r;
  logic [15:0] rem_r, dvs_r;
  logic [4:0]  dcnt_r;
  logic [16:0] trial;
  logic [31:0] page_r;
  logic [15:0] offs_r;

  assign trial = {rem_r, quo_r[31]} - {1'b0, dvs_r};

  // entries
  logic [TlbEntries-1:0] valid_r;
  logic [31:0] epage_r  [TlbEntries];
  logic [19:0] eframe_r [TlbEntries];
  logic [31:0] eins_r   [TlbEntries];
  logic [31:0] euse_r   [TlbEntries];
  logic [31:0] evc_r;

  // scan state
  logic [CntW-1:0] scnt_r;
  logic [IdxW-1:0] sidx;
  logic            found_r, inv_found_r;
  logic [IdxW-1:0] found_idx_r, inv_idx_r, old_idx_r;
  logic [31:0]     old_age_r;
  logic [31:0]     st, age;
  logic            hit_now, dup_now;
  logic [IdxW-1:0] victim;

  assign sidx = scnt_r[IdxW-1:0];
  assign st = policy_r ? eins_r[sidx] : euse_r[sidx];
  assign age = evc_r - st;
  assign hit_now = valid_r[sidx] && (epage_r[sidx] == page_r) && (op_r == CMD_TRANSLATE);
  assign dup_now = valid_r[sidx] && (eframe_r[sidx] == fframe_r);
  assign sts.hit = cmd.scan_step && hit_now;
  assign sts.scan_last = (scnt_r == CntW'(TlbEntries - 1));
  assign sts.div_last = (dcnt_r == 5'd31);

  always_comb begin
    if (found_r) victim = found_idx_r;
    else if (dup_now) victim = sidx;
    else if (inv_found_r) victim = inv_idx_r;
    else if (!valid_r[sidx]) victim = sidx;
    else if (scnt_r == '0 || age > old_age_r) victim = sidx;
    else victim = old_idx_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_command;
      fpage_r <= in_fill_page;
      fframe_r <= in_fill_frame;
      quo_r <= in_logical_address;
      rem_r <= '0;
      dvs_r <= (page_size_r == '0) ? 16'd1 : page_size_r;
      dcnt_r <= '0;
    end else if (cmd.load_div2) begin
      quo_r <= page_r;
      rem_r <= '0;
      dvs_r <= (ept_r == '0) ? 16'd1 : ept_r;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      dcnt_r <= dcnt_r + 5'd1;
      if (!trial[16]) begin
        rem_r <= trial[15:0];
        quo_r <= {quo_r[30:0], 1'b1};
      end else begin
        rem_r <= {rem_r[14:0], quo_r[31]};
        quo_r <= {quo_r[30:0], 1'b0};
      end
      if (sts.div_last && op_r == CMD_TRANSLATE && scnt_r == '0) begin
        page_r <= trial[16] ? {quo_r[30:0], 1'b0} : {quo_r[30:0], 1'b1};
        offs_r <= trial[16] ? {rem_r[14:0], quo_r[31]} : trial[15:0];
      end
    end
  end

  // scan bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.scan_clr) begin
      scnt_r <= '0;
      found_r <= 1'b0;
      inv_found_r <= 1'b0;
      found_idx_r <= '0;
      inv_idx_r <= '0;
      old_idx_r <= '0;
      old_age_r <= '0;
    end else if (cmd.scan_step) begin
      if (!sts.scan_last) scnt_r <= scnt_r + CntW'(1);
      if (hit_now) begin
        found_r <= 1'b1;
        found_idx_r <= sidx;
      end
      if (op_r == CMD_FILL && !found_r && dup_now) begin
        found_r <= 1'b1;
        found_idx_r <= sidx;
      end
      if (!inv_found_r && !valid_r[sidx]) begin
        inv_found_r <= 1'b1;
        inv_idx_r <= sidx;
      end
      if (scnt_r == '0 || age > old_age_r) begin
        old_age_r <= age;
        old_idx_r <= sidx;
      end
    end
  end

  // entry store and stamp counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      evc_r <= '0;
      for (int i = 0; i < TlbEntries; i++) begin
        eins_r[i] <= '0;
        euse_r[i] <= '0;
      end
    end else if (cmd.flush && op_r == CMD_FLUSH) begin
      valid_r <= '0;
      for (int i = 0; i < TlbEntries; i++) begin
        eins_r[i] <= '0;
        euse_r[i] <= '0;
      end
    end else if (cmd.hit_update) begin
      evc_r <= evc_r + 32'd1;
      euse_r[found_idx_r] <= evc_r + 32'd1;
    end else if (cmd.fill_write) begin
      evc_r <= evc_r + 32'd1;
      valid_r[victim] <= 1'b1;
      eins_r[victim] <= evc_r + 32'd1;
      euse_r[victim] <= evc_r + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fill_write) begin
      epage_r[victim] <= fpage_r;
      eframe_r[victim] <= fframe_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= cmd.emit;
    if (cmd.emit) begin
      out_frame <= '0;
      out_offset <= '0;
      out_page_number <= '0;
      out_first_level_index <= '0;
      out_second_level_index <= '0;
      case (op_r)
        CMD_TRANSLATE: begin
          out_offset <= offs_r;
          out_page_number <= page_r;
          if (found_r) begin
            out_status <= ST_HIT;
            out_frame <= eframe_r[found_idx_r];
          end else begin
            out_status <= ST_MISS;
            out_first_level_index <= quo_r;
            out_second_level_index <= rem_r;
          end
        end
        CMD_FILL: out_status <= ST_FILL;
        default:  out_status <= ST_FLUSH;
      endcase
    end
  end
endmodule

// File: hdl/tlb_translate_with_replacement_unit.sv
// Channel  | Ports                                  | Handshake
// input    | in_command, in_logical_address, ...    | start high while busy low
// result   | out_status, out_frame, ...             | out_valid for one cycle
// config   | cfg_we, cfg_index, cfg_data            | write while cfg_we high
// One item at a time. Translate: a divider pass for page and offset, a scan of the
// 16 entries that stops at a hit, then a hit stamp or a second divider pass for the table indexes.
// Fill: a scan of all 16 entries, then the result. Flush: the result only, which clears all entries.
// The serial divider sets the translate time. Reset clears all entries at once.
// Results cannot be stalled.
`include "assert_macros.svh"
module tlb_translate_with_replacement_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_logical_address,
  input  logic [31:0] in_fill_page,
  input  logic [19:0] in_fill_frame,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [19:0] out_frame,
  output logic [15:0] out_offset,
  output logic [31:0] out_page_number,
  output logic [31:0] out_first_level_index,
  output logic [15:0] out_second_level_index
);
  import tlbt_pkg::*;

  tlbt_cmd_t cmd, cmd_q;
  tlbt_sts_t sts;

  tlbt_ctrl u_ctrl (
    .clk, .rst_n, .start, .in_command, .busy, .cmd, .sts
  );

  always_comb begin
    cmd_q = cmd;
    cmd_q.flush = cmd.emit;
  end

  tlbt_dp u_dp (
    .clk, .rst_n, .cmd(cmd_q), .sts,
    .cfg_we, .cfg_index, .cfg_data,
    .in_command, .in_logical_address, .in_fill_page, .in_fill_frame,
    .out_valid, .out_status, .out_frame, .out_offset, .out_page_number,
    .out_first_level_index, .out_second_level_index
  );

  `ASSERT_NEXT(a_emit_idle, clk, rst_n, cmd.emit, !busy)
  `ASSERT_IMPLY(a_one_action, clk, rst_n, 1'b1,
    $onehot0({cmd.hit_update, cmd.fill_write, cmd.emit}))
  `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy && in_command != CMD_FLUSH + 2'd1,
    busy)
endmodule

// File: dv/tb_tlb_translate_with_replacement_unit.sv
module tb_tlb_translate_with_replacement_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import tlbt_pkg::*;

  localparam int NENT = 16;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  status;
    logic [19:0] frame;
    logic [15:0] offset;
    logic [31:0] page_number;
    logic [31:0] first_idx;
    logic [15:0] second_idx;
  } xlat_res_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_command;
  logic [31:0] in_logical_address;
  logic [31:0] in_fill_page;
  logic [19:0] in_fill_frame;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [19:0] out_frame;
  logic [15:0] out_offset;
  logic [31:0] out_page_number;
  logic [31:0] out_first_level_index;
  logic [15:0] out_second_level_index;

  tlb_translate_with_replacement_unit uut (.*);

  // shadow TLB
  logic [15:0] sh_page_size;
  logic [15:0] sh_ept;
  logic        sh_fifo;
  logic        sh_valid [NENT];
  logic [31:0] sh_page [NENT];
  logic [19:0] sh_frame [NENT];
  logic [31:0] sh_ins [NENT];
  logic [31:0] sh_use [NENT];
  logic [31:0] sh_clock;

  xlat_res_t expected_q[$];
  int mismatches;
  int idle_pct;
  bit timed_out;

  // pool of recently filled pages and frames, to steer hits and frame reuse
  logic [31:0] page_pool[$];
  logic [19:0] frame_pool[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_victim();
    int best;
    logic [31:0] best_age;
    logic [31:0] age;
    best = 0;
    best_age = '0;
    for (int i = 0; i < NENT; i++)
      if (!sh_valid[i]) return i;
    for (int i = 0; i < NENT; i++) begin
      age = sh_clock - (sh_fifo ? sh_ins[i] : sh_use[i]);
      if (i == 0 || age > best_age) begin
        best_age = age;
        best = i;
      end
    end
    return best;
  endfunction

  function automatic void install_entry(int i, logic [31:0] pg, logic [19:0] fr);
    sh_clock = sh_clock + 1;
    sh_valid[i] = 1'b1;
    sh_page[i] = pg;
    sh_frame[i] = fr;
    sh_ins[i] = sh_clock;
    sh_use[i] = sh_clock;
  endfunction

  // returns 0 when the command produces no result
  function automatic bit predict_lookup(logic [1:0] cmd, logic [31:0] addr,
                                        logic [31:0] fpg, logic [19:0] ffr,
                                        output xlat_res_t r);
    logic [31:0] ps;
    logic [31:0] ept;
    logic [31:0] pg;
    int slot;
    r = '0;
    case (cmd)
      CMD_TRANSLATE: begin
        ps = (sh_page_size == 0) ? 32'd1 : {16'd0, sh_page_size};
        ept = (sh_ept == 0) ? 32'd1 : {16'd0, sh_ept};
        pg = addr / ps;
        r.offset = 16'(addr % ps);
        r.page_number = pg;
        for (int i = 0; i < NENT; i++) begin
          if (sh_valid[i] && sh_page[i] == pg) begin
            sh_clock = sh_clock + 1;
            sh_use[i] = sh_clock;
            r.status = ST_HIT;
            r.frame = sh_frame[i];
            return 1'b1;
          end
        end
        r.status = ST_MISS;
        r.first_idx = pg / ept;
        r.second_idx = 16'(pg % ept);
        return 1'b1;
      end
      CMD_FILL: begin
        slot = -1;
        for (int i = 0; i < NENT; i++)
          if (slot < 0 && sh_valid[i] && sh_frame[i] == ffr) slot = i;
        if (slot < 0) slot = pick_victim();
        install_entry(slot, fpg, ffr);
        r.status = ST_FILL;
        return 1'b1;
      end
      CMD_FLUSH: begin
        for (int i = 0; i < NENT; i++) begin
          sh_valid[i] = 1'b0;
          sh_ins[i] = '0;
          sh_use[i] = '0;
        end
        r.status = ST_FLUSH;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // start stays high after a transfer until the next item or an idle cycle drops it
  task automatic send_cmd(logic [1:0] cmd, logic [31:0] addr,
                          logic [31:0] fpg, logic [19:0] ffr);
    xlat_res_t r;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_command <= cmd;
    in_logical_address <= addr;
    in_fill_page <= fpg;
    in_fill_frame <= ffr;
    @(posedge clk);
    while (busy) @(posedge clk);
    // transfer taken at this edge
    if (predict_lookup(cmd, addr, fpg, ffr, r)) expected_q.push_back(r);
    if (cmd == CMD_FILL) begin
      page_pool.push_back(fpg);
      frame_pool.push_back(ffr);
      if (page_pool.size() > 24) begin
        void'(page_pool.pop_front());
        void'(frame_pool.pop_front());
      end
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_PAGE_SIZE: sh_page_size = val;
      REG_EPT:       sh_ept = val;
      REG_POLICY:    sh_fifo = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [15:0] ps, logic [15:0] ept, logic pol);
    settle();
    write_reg(REG_PAGE_SIZE, ps);
    write_reg(REG_EPT, ept);
    write_reg(REG_POLICY, {15'd0, pol});
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] addr_of_page(logic [31:0] pg);
    logic [31:0] ps;
    ps = (sh_page_size == 0) ? 32'd1 : {16'd0, sh_page_size};
    return pg * ps + ($urandom % ps);
  endfunction

  // collect results; the receiver never stalls
  always @(posedge clk) begin
    xlat_res_t got;
    xlat_res_t want;
    if (rst_n && out_valid) begin
      got = '{out_status, out_frame, out_offset, out_page_number,
              out_first_level_index, out_second_level_index};
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  task automatic test_directed();
    send_cmd(CMD_TRANSLATE, 32'd0, '0, '0);
    send_cmd(CMD_TRANSLATE, 32'hFFFF_FFFF, '0, '0);
    send_cmd(CMD_FILL, '0, 32'hFFFF_FFFF, 20'hFFFFF);
    send_cmd(CMD_TRANSLATE, 32'hFFFF_FFFF, '0, '0);
    send_cmd(CMD_FILL, '0, 32'd0, 20'd0);
    send_cmd(CMD_TRANSLATE, 32'd63, '0, '0);
    // same frame again: existing entry is retargeted
    send_cmd(CMD_FILL, '0, 32'd5, 20'd0);
    send_cmd(CMD_TRANSLATE, 32'd5 * 64 + 3, '0, '0);
    send_cmd(CMD_TRANSLATE, 32'd0, '0, '0);
    // duplicate page held by two entries
    send_cmd(CMD_FILL, '0, 32'd5, 20'h12345);
    send_cmd(CMD_TRANSLATE, 32'd5 * 64, '0, '0);
    send_cmd(CMD_UNUSED, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 20'hAAAAA);
    send_cmd(CMD_FLUSH, '0, '0, '0);
    send_cmd(CMD_TRANSLATE, 32'd5 * 64, '0, '0);
    // zero divisors act as one
    set_config(16'd0, 16'd0, 1'b0);
    send_cmd(CMD_TRANSLATE, 32'h1234_5678, '0, '0);
    set_config(16'hFFFF, 16'hFFFF, 1'b1);
    send_cmd(CMD_TRANSLATE, 32'hFFFF_FFFF, '0, '0);
    send_cmd(CMD_TRANSLATE, 32'h0001_0000, '0, '0);
  endtask

  // overflow the table so victims are chosen among full entries
  task automatic test_replacement(logic pol);
    logic [31:0] pg;
    set_config(16'd16, 16'd8, pol);
    send_cmd(CMD_FLUSH, '0, '0, '0);
    for (int i = 0; i < 20; i++) begin
      send_cmd(CMD_FILL, '0, 32'(100 + i), 20'(i + 1));
      if (i % 3 == 0) send_cmd(CMD_TRANSLATE, (32'd100 + $urandom_range(i)) * 16, '0, '0);
    end
    for (int i = 0; i < 24; i++) begin
      pg = 32'(100 + $urandom_range(23));
      send_cmd(CMD_TRANSLATE, pg * 16 + $urandom_range(15), '0, '0);
    end
  endtask

  task automatic test_random(int n);
    int sel;
    logic [1:0] cmd;
    logic [31:0] addr;
    logic [31:0] fpg;
    logic [19:0] ffr;
    for (int k = 0; k < n; k++) begin
      if (k == n / 3) idle_pct = 0;
      if (k == n / 2) idle_pct = 28;
      if (k % 90 == 89) begin
        case ($urandom_range(3))
          0: set_config(16'($urandom_range(1, 64)), 16'($urandom_range(1, 8)),
                        1'($urandom));
          1: set_config(16'($urandom), 16'($urandom), 1'($urandom));
          2: set_config(16'd1, 16'd1, 1'($urandom));
          default: set_config(16'hFFFF, 16'd0, 1'($urandom));
        endcase
      end
      sel = $urandom_range(99);
      addr = $urandom;
      fpg = $urandom;
      ffr = 20'($urandom);
      if (sel < 45) begin
        cmd = CMD_TRANSLATE;
        if (page_pool.size() != 0 && $urandom_range(2) != 0)
          addr = addr_of_page(page_pool[$urandom_range(page_pool.size() - 1)]);
      end else if (sel < 88) begin
        cmd = CMD_FILL;
        if ($urandom_range(1)) fpg = 32'($urandom_range(40));
        if (frame_pool.size() != 0 && $urandom_range(3) == 0)
          ffr = frame_pool[$urandom_range(frame_pool.size() - 1)];
      end else if (sel < 95) begin
        cmd = CMD_FLUSH;
      end else begin
        cmd = CMD_UNUSED;
      end
      send_cmd(cmd, addr, fpg, ffr);
    end
  endtask

  initial begin
    timed_out = 1'b0;
    #20ms;
    timed_out = 1'b1;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_command = '0;
    in_logical_address = '0;
    in_fill_page = '0;
    in_fill_frame = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    idle_pct = 28;
    sh_page_size = 16'd64;
    sh_ept = 16'd4;
    sh_fifo = 1'b0;
    sh_clock = '0;
    for (int i = 0; i < NENT; i++) begin
      sh_valid[i] = 1'b0;
      sh_page[i] = '0;
      sh_frame[i] = '0;
      sh_ins[i] = '0;
      sh_use[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_replacement(1'b0);
    test_replacement(1'b1);
    set_config(16'd64, 16'd4, 1'b0);
    test_random(425);
    settle();
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
